[hw/rtl/slf_pkg.sv]
// Shared types, character codes and limits of the list framer.
package slf_pkg;

  localparam int unsigned MaxDepth = 255;
  localparam logic [7:0] DepthLimit = (MaxDepth < 255) ? 8'(MaxDepth) : 8'd255;

  localparam logic [15:0] MaxLengthReset = 16'd4096;

  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;

  localparam logic [15:0] ElemMax = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_SPACE      = 4'd0,
    ST_OPENED     = 4'd1,
    ST_INSIDE     = 4'd2,
    ST_DONE       = 4'd3,
    ST_STREAM_END = 4'd4,
    ST_NOT_LIST   = 4'd5,
    ST_EARLY_END  = 4'd6,
    ST_TOO_LONG   = 4'd7,
    ST_TOO_DEEP   = 4'd8
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  byte_echo;
    logic [7:0]  nesting_level;
    logic        element_starts;
    logic        element_ends;
    logic [15:0] element_total;
  } result_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       end_of_input;
  } item_t;

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == ChSpace) || (c == ChNl) || (c == ChTab);
  endfunction

endpackage

[hw/rtl/slf_apb.sv]
// Configuration register file with an APB-style access port.
module slf_apb import slf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] max_length_o
);

  logic [15:0] max_length_q, max_length_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_comb begin
    max_length_d = max_length_q;
    if (wr_en) begin
      max_length_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MaxLengthReset;
    end else begin
      max_length_q <= max_length_d;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == 1'b0) begin
      prdata = {16'd0, max_length_q};
    end
  end

  assign max_length_o = max_length_q;

endmodule

[hw/rtl/slf_step.sv]
// Per-byte framing logic and the list state it updates.
module slf_step import slf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  item_t       item_i,
  input  logic [15:0] max_length_i,
  output result_t     result_o
);

  logic        phase_q, phase_d;
  logic [7:0]  depth_q, depth_d;
  logic [15:0] bytes_q, bytes_d;
  logic [15:0] elems_q, elems_d;
  logic        atom_q, atom_d;

  logic [7:0]  c;
  logic        eoi;
  logic [15:0] elems_inc;

  assign c         = item_i.data_byte;
  assign eoi       = item_i.end_of_input;
  assign elems_inc = (elems_q == ElemMax) ? elems_q : elems_q + 16'd1;

  always_comb begin
    phase_d  = phase_q;
    depth_d  = depth_q;
    bytes_d  = bytes_q;
    elems_d  = elems_q;
    atom_d   = atom_q;
    result_o = '0;
    if (!phase_q) begin
      if (eoi) begin
        result_o.status = ST_STREAM_END;
      end else if (c == ChOpen) begin
        phase_d  = 1'b1;
        depth_d  = 8'd1;
        bytes_d  = 16'd1;
        elems_d  = 16'd0;
        atom_d   = 1'b0;
        result_o.status        = ST_OPENED;
        result_o.byte_echo     = c;
        result_o.nesting_level = 8'd1;
      end else if (is_blank(c)) begin
        result_o.status = ST_SPACE;
      end else begin
        result_o.status = ST_NOT_LIST;
      end
    end else if (eoi || (bytes_q >= max_length_i) ||
                 ((c == ChOpen) && (depth_q >= DepthLimit))) begin
      phase_d = 1'b0;
      depth_d = 8'd0;
      bytes_d = 16'd0;
      elems_d = 16'd0;
      atom_d  = 1'b0;
      if (eoi) begin
        result_o.status = ST_EARLY_END;
      end else if (bytes_q >= max_length_i) begin
        result_o.status = ST_TOO_LONG;
      end else begin
        result_o.status = ST_TOO_DEEP;
      end
    end else if ((c == ChClose) && (depth_q <= 8'd1)) begin
      phase_d = 1'b0;
      depth_d = 8'd0;
      bytes_d = 16'd0;
      elems_d = 16'd0;
      atom_d  = 1'b0;
      result_o.status        = ST_DONE;
      result_o.byte_echo     = c;
      result_o.element_ends  = atom_q;
      result_o.element_total = elems_q;
    end else begin
      if (c == ChOpen) begin
        if (depth_q <= 8'd1) begin
          result_o.element_ends   = atom_q;
          result_o.element_starts = 1'b1;
          atom_d  = 1'b0;
          elems_d = elems_inc;
        end
        depth_d = depth_q + 8'd1;
      end else if (c == ChClose) begin
        depth_d = depth_q - 8'd1;
        result_o.element_ends = (depth_q == 8'd2);
      end else if (depth_q <= 8'd1) begin
        if (is_blank(c)) begin
          result_o.element_ends = atom_q;
          atom_d = 1'b0;
        end else if (!atom_q) begin
          result_o.element_starts = 1'b1;
          atom_d  = 1'b1;
          elems_d = elems_inc;
        end
      end
      bytes_d = bytes_q + 16'd1;
      result_o.status        = ST_INSIDE;
      result_o.byte_echo     = c;
      result_o.nesting_level = depth_d;
      result_o.element_total = elems_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      depth_q <= 8'd0;
      bytes_q <= 16'd0;
      elems_q <= 16'd0;
      atom_q  <= 1'b0;
    end else if (step_i && item_i.data_valid) begin
      phase_q <= phase_d;
      depth_q <= depth_d;
      bytes_q <= bytes_d;
      elems_q <= elems_d;
      atom_q  <= atom_d;
    end
  end

endmodule

[hw/rtl/sexpr_list_framer.sv]
// Top level of the list framer: item register, framing step, result register, config port.
// One byte is taken per clock cycle at full rate; its result reaches the master side through
// the input register and then the result register. The framing state (depth, byte count,
// element count, atom flag) is updated in the single step between the two registers, so
// back-to-back items see each other's effect with no bubbles. A stalled master side holds the
// result register, then fills the input register, then drops s_axis_tready. max_length
// is to be written through the APB port only while the stream is idle; the block itself
// does not enforce this.
module sexpr_list_framer import slf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] byte_echo, [15:8] nesting_level, [16] element_starts, [17] element_ends,
  // [33:18] element_total, [39:34] zero
  output logic [39:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,   // [3:0] status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  item_t       item_q, item_d;
  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d;
  result_t     step_res;
  logic        out_adv;
  logic        in_take;
  logic [15:0] max_length;

  slf_apb u_apb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_length_o (max_length)
  );

  slf_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (out_adv),
    .item_i       (item_q),
    .max_length_i (max_length),
    .result_o     (step_res)
  );

  assign out_adv       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !item_q.data_valid || out_adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d = item_q;
    if (in_take) begin
      item_d.data_valid   = 1'b1;
      item_d.data_byte    = s_axis_tdata;
      item_d.end_of_input = s_axis_tlast;
    end else if (out_adv) begin
      item_d.data_valid = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (out_adv) begin
      out_valid_d = item_q.data_valid;
      res_d       = step_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q      <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      item_q      <= item_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {6'd0, res_q.element_total, res_q.element_ends,
                          res_q.element_starts, res_q.nesting_level, res_q.byte_echo};

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.status == ST_EARLY_END || res_q.status == ST_TOO_LONG ||
                     res_q.status == ST_TOO_DEEP)) |-> (m_axis_tdata == 40'd0))
    else $error("error result carries nonzero fields");

  a_done_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status == ST_DONE) |->
      (res_q.nesting_level == 8'd0 && res_q.byte_echo == ChClose))
    else $error("list done without closing byte at level zero");

  a_open_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status == ST_OPENED) |->
      (res_q.nesting_level == 8'd1 && res_q.byte_echo == ChOpen))
    else $error("opened list not at level one");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (out_valid_q && !m_axis_tready && item_q.data_valid))
    else $error("input stalled without a full pipeline");

  a_inside_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status == ST_INSIDE) |-> (res_q.nesting_level != 8'd0))
    else $error("item inside a list reported at level zero");

endmodule

[test/testbench.sv]
// Self-checking testbench for the list framer: directed and random byte streams.
module testbench;
  import slf_pkg::*;

  localparam logic [2:0] AddrMaxLength = 3'd0;
  localparam int HoldCycles = 60;
  localparam int DrainCycles = 4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] data_byte
  logic        s_axis_tlast = 1'b0;     // end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] byte_echo, [15:8] nesting_level, [16] element_starts, [17] element_ends,
  // [33:18] element_total, [39:34] zero
  logic [39:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;            // [3:0] status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  sexpr_list_framer u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // framing state mirrored from the block
  bit          in_list = 1'b0;
  logic [7:0]  depth_q = 8'd0;
  logic [15:0] len_q = 16'd0;
  logic [15:0] elem_q = 16'd0;
  bit          atom_open = 1'b0;
  logic [15:0] max_len = MaxLengthReset;

  result_t     expected_results[$];
  bit          gaps_on = 1'b1;
  bit          rx_hold = 1'b0;
  int          rx_pause = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          lists_closed = 0;
  int          error_results = 0;
  int          mismatches = 0;
  result_t     got;
  result_t     want;
  event        hold_off_ev;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  function automatic bit is_space(logic [7:0] c);
    return c == ChSpace || c == ChNl || c == ChTab;
  endfunction

  function automatic void abandon_list();
    in_list = 1'b0;
    depth_q = 8'd0;
    len_q = 16'd0;
    elem_q = 16'd0;
    atom_open = 1'b0;
  endfunction

  function automatic void bump_elements();
    if (elem_q != ElemMax) elem_q = elem_q + 16'd1;
  endfunction

  function automatic result_t frame_step(logic [7:0] c, logic eoi);
    result_t r;
    r = '0;
    if (!in_list) begin
      if (eoi) begin
        r.status = ST_STREAM_END;
      end else if (c == ChOpen) begin
        abandon_list();
        in_list = 1'b1;
        depth_q = 8'd1;
        len_q = 16'd1;
        r.status = ST_OPENED;
        r.byte_echo = c;
        r.nesting_level = 8'd1;
      end else if (is_space(c)) begin
        r.status = ST_SPACE;
      end else begin
        r.status = ST_NOT_LIST;
      end
      return r;
    end
    if (eoi) begin
      abandon_list();
      r.status = ST_EARLY_END;
      return r;
    end
    if (len_q >= max_len) begin
      abandon_list();
      r.status = ST_TOO_LONG;
      return r;
    end
    if (c == ChOpen) begin
      if (depth_q >= DepthLimit) begin
        abandon_list();
        r.status = ST_TOO_DEEP;
        return r;
      end
      if (depth_q <= 8'd1) begin
        r.element_ends = atom_open;
        atom_open = 1'b0;
        r.element_starts = 1'b1;
        bump_elements();
      end
      depth_q = depth_q + 8'd1;
    end else if (c == ChClose) begin
      if (depth_q <= 8'd1) begin
        r.status = ST_DONE;
        r.byte_echo = c;
        r.element_ends = atom_open;
        r.element_total = elem_q;
        abandon_list();
        return r;
      end
      depth_q = depth_q - 8'd1;
      if (depth_q == 8'd1) r.element_ends = 1'b1;
    end else if (depth_q <= 8'd1) begin
      if (is_space(c)) begin
        r.element_ends = atom_open;
        atom_open = 1'b0;
      end else if (!atom_open) begin
        r.element_starts = 1'b1;
        atom_open = 1'b1;
        bump_elements();
      end
    end
    len_q = len_q + 16'd1;
    r.status = ST_INSIDE;
    r.byte_echo = c;
    r.nesting_level = depth_q;
    r.element_total = elem_q;
    return r;
  endfunction

  function automatic logic [7:0] atom_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == ChOpen || c == ChClose || is_space(c));
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 2))
      0: return ChSpace;
      1: return ChNl;
      default: return ChTab;
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eoi);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= eoi;
    do @(posedge clk_i);
    while (!s_axis_tready);
    expected_results.push_back(frame_step(c, eoi));
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic drain_stream();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_max_length(input logic [15:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrMaxLength;
    pwdata <= {16'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    max_len = v;
  endtask

  task automatic send_random_list();
    int lvl;
    int steps;
    lvl = 1;
    steps = $urandom_range(1, 12);
    send_char(ChOpen, 1'b0);
    for (int k = 0; k < steps; k++) begin
      case ($urandom_range(0, 5))
        0: if (lvl < 5) begin
          send_char(ChOpen, 1'b0);
          lvl++;
        end
        1: if (lvl > 1) begin
          send_char(ChClose, 1'b0);
          lvl--;
        end
        2: send_char(blank_char(), 1'b0);
        default: begin
          repeat ($urandom_range(1, 3)) send_char(atom_char(), 1'b0);
          if ($urandom_range(0, 1) == 0) send_char(blank_char(), 1'b0);
        end
      endcase
      if ($urandom_range(0, 60) == 0) begin
        send_char(8'($urandom_range(0, 255)), 1'b1);
        return;
      end
    end
    while (lvl > 0) begin
      send_char(ChClose, 1'b0);
      lvl--;
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_char(8'($urandom_range(0, 255)), 1'b1);
      1: send_char(blank_char(), 1'b0);
      default: send_char(8'($urandom_range(0, 255)), 1'b0);
    endcase
  endtask

  task automatic test_directed();
    send_char(ChSpace, 1'b0);
    send_char(ChNl, 1'b0);
    send_char(ChTab, 1'b0);
    send_char(8'h78, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(ChClose, 1'b0);
    send_char(8'hA5, 1'b1);
    send_text("(a b)");
    send_text("(a(b)c)");
    send_text("()");
    send_text("(a");
    send_char(8'h5A, 1'b1);
    drain_stream();
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    -> hold_off_ev;
    send_char(ChOpen, 1'b0);
    repeat (38) send_char(atom_char(), 1'b0);
    send_char(ChClose, 1'b0);
    drain_stream();
    gaps_on = 1'b1;
  endtask

  task automatic test_length_limit();
    write_max_length(16'd3);
    send_text("(a)");
    send_text("(ab)");
    drain_stream();
    write_max_length(16'd2);
    send_text("()");
    send_text("(a)");
    drain_stream();
  endtask

  task automatic test_depth_limit();
    write_max_length(16'hFFFF);
    repeat (255) send_char(ChOpen, 1'b0);
    send_char(ChOpen, 1'b0);
    drain_stream();
  endtask

  task automatic test_random();
    logic [15:0] lengths[4];
    int start;
    lengths[0] = MaxLengthReset;
    lengths[1] = 16'($urandom_range(2, 16));
    lengths[2] = 16'hFFFF;
    lengths[3] = 16'($urandom_range(2, 65535));
    foreach (lengths[p]) begin
      write_max_length(lengths[p]);
      start = items_sent;
      while (items_sent - start < 30) begin
        if ($urandom_range(0, 5) == 0) send_noise();
        else send_random_list();
      end
      drain_stream();
    end
  endtask

  task automatic test_steady_stream();
    gaps_on = 1'b0;
    write_max_length(MaxLengthReset);
    repeat (6) send_random_list();
    send_char(8'h00, 1'b1);
    drain_stream();
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("tb: %s: expected st=%0d echo=%02h lvl=%0d s=%0b e=%0b tot=%0d", what,
               want.status, want.byte_echo, want.nesting_level, want.element_starts,
               want.element_ends, want.element_total);
      $display("tb:   got      st=%0d echo=%02h lvl=%0d s=%0b e=%0b tot=%0d",
               got.status, got.byte_echo, got.nesting_level, got.element_starts,
               got.element_ends, got.element_total);
    end
  endtask

  initial begin
    forever begin
      @(hold_off_ev);
      @(negedge clk_i);
      rx_hold = 1'b1;
      repeat (HoldCycles) @(negedge clk_i);
      rx_hold = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = status_e'(m_axis_tuser);
      got.byte_echo = m_axis_tdata[7:0];
      got.nesting_level = m_axis_tdata[15:8];
      got.element_starts = m_axis_tdata[16];
      got.element_ends = m_axis_tdata[17];
      got.element_total = m_axis_tdata[33:18];
      results_checked++;
      if (got.status == ST_DONE) lists_closed++;
      if (got.status >= ST_EARLY_END) error_results++;
      if (expected_results.size() == 0) begin
        want = '0;
        report_mismatch("unexpected result");
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.byte_echo !== want.byte_echo ||
            got.nesting_level !== want.nesting_level ||
            got.element_starts !== want.element_starts ||
            got.element_ends !== want.element_ends ||
            got.element_total !== want.element_total) begin
          report_mismatch("mismatch");
        end
      end
    end
    if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else if (rx_pause > 0) begin
      m_axis_tready <= 1'b0;
      rx_pause = rx_pause - 1;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      rx_pause = $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    int errors;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_length_limit();
    test_depth_limit();
    test_random();
    test_steady_stream();
    errors = mismatches + expected_results.size();
    $display("tb: %0d items sent, %0d results checked, %0d lists closed, %0d error results",
             items_sent, results_checked, lists_closed, error_results);
    $display("tb: max_length from 2 to 65535, nesting to 255, receiver hold-off of %0d cycles",
             HoldCycles);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/slf_pkg.sv
hw/rtl/slf_apb.sv
hw/rtl/slf_step.sv
hw/rtl/sexpr_list_framer.sv
test/testbench.sv
